/* rtl/core/kst_pkg.sv */
// types and constants shared by the keyed semaphore table
package kst_pkg;

    // operation codes carried in the request mode field
    localparam logic [1:0] MODE_GET   = 2'd0;
    localparam logic [1:0] MODE_CLOSE = 2'd1;
    localparam logic [1:0] MODE_DOWN  = 2'd2;
    localparam logic [1:0] MODE_UP    = 2'd3;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // saturation limits and reset key
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [10:0] REFS_MAX  = 11'h7FF;
    localparam logic [31:0] KEY_RESET = 32'hFFFF_FFFF;

    // request transaction
    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         proc_id;
        logic signed [31:0] key;
        logic [15:0]        start_count;
        logic [3:0]         sid;
    } req_t;

    // response transaction
    typedef struct packed {
        logic       status;
        logic [3:0] sid_out;
    } rsp_t;

    // one semaphore table entry
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] count;
        logic [10:0] refs;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GDSCAN,
        ST_GESCAN,
        ST_GWRITE,
        ST_OADDR,
        ST_OD,
        ST_OE,
        ST_FINISH
    } state_t;

endpackage

/* rtl/core/keyed_semaphore_table_unit.sv */
// keyed semaphore table: top level with entry and descriptor memories
//
// Requests arrive on req (req_valid / req_stall), one transaction per operation:
// get, close, down or up on behalf of a process. Each request gives exactly one
// response on rsp (rsp_valid / rsp_stall) carrying a status and, for a good get,
// the granted descriptor.
// One request is worked on at a time. A get scans the process's descriptor slots
// and then the entry table, one memory read issued per cycle. Close, down and up
// read the descriptor slot, then its entry, and write back the changed entry.
// Each memory has a single read port.
// After reset the descriptor memory is cleared, one slot per cycle, with
// req_stall high meanwhile. Entry state resets at once through per-entry valid
// bits.
// The response sits in an output register; while rsp_stall holds it, the next
// request is still taken and worked on, and only its result waits.
module keyed_semaphore_table_unit #(
    parameter int TABLE_ENTRIES = 32,
    parameter int DESCRIPTORS   = 16,
    parameter int PROCESSES     = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  kst_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kst_pkg::rsp_t rsp
);

    localparam int DDEPTH = PROCESSES * DESCRIPTORS;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int DIW    = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
    localparam int EIW    = $clog2(TABLE_ENTRIES);

    localparam logic [DIW-1:0] D_LAST = DIW'(DESCRIPTORS - 1);
    localparam logic [EIW-1:0] E_LAST = EIW'(TABLE_ENTRIES - 1);
    localparam logic [DAW-1:0] C_LAST = DAW'(DDEPTH - 1);

    localparam kst_pkg::entry_t ENTRY_RESET = '{key: kst_pkg::KEY_RESET,
                                                count: 16'd0, refs: 11'd0};

    // memories
    kst_pkg::entry_t emem [TABLE_ENTRIES];
    logic [EIW:0]    dmem [DDEPTH];

    kst_pkg::entry_t em_rdata_reg;
    logic [EIW:0]    dm_rdata_reg;

    logic            em_re, em_we;
    logic [EIW-1:0]  em_raddr, em_waddr;
    kst_pkg::entry_t em_wdata;
    logic            dm_re, dm_we;
    logic [DAW-1:0]  dm_raddr, dm_waddr;
    logic [EIW:0]    dm_wdata;

    // control and request registers
    kst_pkg::state_t    state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [31:0]        key_reg, key_next;
    logic [15:0]        init_reg, init_next;
    logic [3:0]         sid_reg, sid_next;
    logic [DAW-1:0]     base_reg, base_next;
    logic [DIW-1:0]     dcnt_reg, dcnt_next;
    logic [DIW-1:0]     pidx_reg, pidx_next;
    logic [DIW-1:0]     free_d_reg, free_d_next;
    logic [EIW-1:0]     ecnt_reg, ecnt_next;
    logic [EIW-1:0]     peidx_reg, peidx_next;
    logic [EIW-1:0]     sel_reg, sel_next;
    logic [EIW-1:0]     vac_reg, vac_next;
    logic               vac_found_reg, vac_found_next;
    logic               hit_reg, hit_next;
    logic               pend_reg, pend_next;
    logic [DAW-1:0]     ccnt_reg, ccnt_next;
    kst_pkg::entry_t    ent_reg, ent_next;
    kst_pkg::rsp_t      res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    kst_pkg::rsp_t      rsp_reg, rsp_next;
    logic [TABLE_ENTRIES-1:0] evld_reg, evld_next;

    logic               req_take;
    logic [15:0]        base_full;
    logic [EIW-1:0]     eidx_look;
    kst_pkg::entry_t    ent_rd;
    logic [DAW-1:0]     addr_scan, addr_free, addr_sid;

    assign req_stall = (state_reg != kst_pkg::ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // descriptor slot addresses
    assign base_full = 16'(req.proc_id) * 16'(DESCRIPTORS);
    assign addr_scan = base_reg + DAW'(dcnt_reg);
    assign addr_free = base_reg + DAW'(free_d_reg);
    assign addr_sid  = base_reg + DAW'(sid_reg);

    // entry read data, reset value where never written
    assign eidx_look = (state_reg == kst_pkg::ST_GESCAN) ? peidx_reg : sel_reg;
    assign ent_rd    = evld_reg[eidx_look] ? em_rdata_reg : ENTRY_RESET;

    // entry memory
    always_ff @(posedge clk)
    begin
        if (em_we)
        begin
            emem[em_waddr] <= em_wdata;
        end
        if (em_re)
        begin
            em_rdata_reg <= emem[em_raddr];
        end
    end

    // descriptor memory
    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_waddr] <= dm_wdata;
        end
        if (dm_re)
        begin
            dm_rdata_reg <= dmem[dm_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kst_pkg::ST_CLEAR;
            ccnt_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            evld_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ccnt_reg      <= ccnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            evld_reg      <= evld_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        init_reg      <= init_next;
        sid_reg       <= sid_next;
        base_reg      <= base_next;
        dcnt_reg      <= dcnt_next;
        pidx_reg      <= pidx_next;
        free_d_reg    <= free_d_next;
        ecnt_reg      <= ecnt_next;
        peidx_reg     <= peidx_next;
        sel_reg       <= sel_next;
        vac_reg       <= vac_next;
        vac_found_reg <= vac_found_next;
        hit_reg       <= hit_next;
        ent_reg       <= ent_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        init_next      = init_reg;
        sid_next       = sid_reg;
        base_next      = base_reg;
        dcnt_next      = dcnt_reg;
        pidx_next      = pidx_reg;
        free_d_next    = free_d_reg;
        ecnt_next      = ecnt_reg;
        peidx_next     = peidx_reg;
        sel_next       = sel_reg;
        vac_next       = vac_reg;
        vac_found_next = vac_found_reg;
        hit_next       = hit_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        ccnt_next      = ccnt_reg;
        pend_next      = 1'b0;
        evld_next      = evld_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        em_re    = 1'b0;
        em_raddr = ecnt_reg;
        em_we    = 1'b0;
        em_waddr = sel_reg;
        em_wdata = ent_rd;
        dm_re    = 1'b0;
        dm_raddr = addr_scan;
        dm_we    = 1'b0;
        dm_waddr = addr_sid;
        dm_wdata = '0;

        case (state_reg)
            // clear descriptor memory after reset
            kst_pkg::ST_CLEAR:
            begin
                dm_we    = 1'b1;
                dm_waddr = ccnt_reg;
                dm_wdata = '0;
                if (ccnt_reg == C_LAST)
                begin
                    state_next = kst_pkg::ST_IDLE;
                end
                else
                begin
                    ccnt_next = ccnt_reg + 1'b1;
                end
            end

            // take a transaction and dispatch
            kst_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    mode_next      = req.mode;
                    key_next       = req.key;
                    init_next      = req.start_count;
                    sid_next       = req.sid;
                    base_next      = DAW'(base_full);
                    dcnt_next      = '0;
                    ecnt_next      = '0;
                    vac_found_next = 1'b0;
                    res_next       = '{status: kst_pkg::STATUS_FAIL, sid_out: 4'd0};
                    if (32'(req.proc_id) >= PROCESSES)
                    begin
                        state_next = kst_pkg::ST_FINISH;
                    end
                    else if (req.mode == kst_pkg::MODE_GET)
                    begin
                        state_next = kst_pkg::ST_GDSCAN;
                    end
                    else if (32'(req.sid) >= DESCRIPTORS)
                    begin
                        state_next = kst_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = kst_pkg::ST_OADDR;
                    end
                end
            end

            // get: find lowest empty descriptor slot
            kst_pkg::ST_GDSCAN:
            begin
                dm_re     = 1'b1;
                dm_raddr  = addr_scan;
                pend_next = 1'b1;
                pidx_next = dcnt_reg;
                if (dcnt_reg != D_LAST)
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (!dm_rdata_reg[EIW])
                    begin
                        free_d_next = pidx_reg;
                        pend_next   = 1'b0;
                        state_next  = kst_pkg::ST_GESCAN;
                    end
                    else if (pidx_reg == D_LAST)
                    begin
                        pend_next  = 1'b0;
                        state_next = kst_pkg::ST_FINISH;
                    end
                end
            end

            // get: first key match, else first entry with no references
            kst_pkg::ST_GESCAN:
            begin
                em_re      = 1'b1;
                em_raddr   = ecnt_reg;
                pend_next  = 1'b1;
                peidx_next = ecnt_reg;
                if (ecnt_reg != E_LAST)
                begin
                    ecnt_next = ecnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (ent_rd.key == key_reg)
                    begin
                        sel_next   = peidx_reg;
                        ent_next   = ent_rd;
                        hit_next   = 1'b1;
                        pend_next  = 1'b0;
                        state_next = kst_pkg::ST_GWRITE;
                    end
                    else
                    begin
                        if (!vac_found_reg && ent_rd.refs == 11'd0)
                        begin
                            vac_found_next = 1'b1;
                            vac_next       = peidx_reg;
                        end
                        if (peidx_reg == E_LAST)
                        begin
                            pend_next = 1'b0;
                            hit_next  = 1'b0;
                            if (vac_found_reg)
                            begin
                                sel_next   = vac_reg;
                                state_next = kst_pkg::ST_GWRITE;
                            end
                            else if (ent_rd.refs == 11'd0)
                            begin
                                sel_next   = peidx_reg;
                                state_next = kst_pkg::ST_GWRITE;
                            end
                            else
                            begin
                                state_next = kst_pkg::ST_FINISH;
                            end
                        end
                    end
                end
            end

            // get: update entry and bind descriptor
            kst_pkg::ST_GWRITE:
            begin
                em_we    = 1'b1;
                em_waddr = sel_reg;
                if (hit_reg)
                begin
                    em_wdata = ent_reg;
                    if (ent_reg.refs != kst_pkg::REFS_MAX)
                    begin
                        em_wdata.refs = ent_reg.refs + 11'd1;
                    end
                end
                else
                begin
                    em_wdata = '{key: key_reg, count: init_reg, refs: 11'd1};
                end
                evld_next[sel_reg] = 1'b1;
                dm_we      = 1'b1;
                dm_waddr   = addr_free;
                dm_wdata   = {1'b1, sel_reg};
                res_next   = '{status: kst_pkg::STATUS_OK, sid_out: 4'(free_d_reg)};
                state_next = kst_pkg::ST_FINISH;
            end

            // close, down, up: read descriptor slot
            kst_pkg::ST_OADDR:
            begin
                dm_re      = 1'b1;
                dm_raddr   = addr_sid;
                state_next = kst_pkg::ST_OD;
            end

            // check binding and read its entry
            kst_pkg::ST_OD:
            begin
                if (dm_rdata_reg[EIW])
                begin
                    em_re      = 1'b1;
                    em_raddr   = dm_rdata_reg[EIW-1:0];
                    sel_next   = dm_rdata_reg[EIW-1:0];
                    state_next = kst_pkg::ST_OE;
                end
                else
                begin
                    state_next = kst_pkg::ST_FINISH;
                end
            end

            // modify and write back the entry; a down on a zero count writes nothing
            kst_pkg::ST_OE:
            begin
                em_waddr   = sel_reg;
                em_wdata   = ent_rd;
                state_next = kst_pkg::ST_FINISH;
                case (mode_reg)
                    kst_pkg::MODE_CLOSE:
                    begin
                        if (ent_rd.refs != 11'd0)
                        begin
                            em_wdata.refs = ent_rd.refs - 11'd1;
                        end
                        em_we    = 1'b1;
                        dm_we    = 1'b1;
                        dm_waddr = addr_sid;
                        dm_wdata = '0;
                        res_next = '{status: kst_pkg::STATUS_OK, sid_out: 4'd0};
                    end
                    kst_pkg::MODE_DOWN:
                    begin
                        if (ent_rd.count != 16'd0)
                        begin
                            em_wdata.count = ent_rd.count - 16'd1;
                            em_we          = 1'b1;
                            res_next = '{status: kst_pkg::STATUS_OK, sid_out: 4'd0};
                        end
                    end
                    kst_pkg::MODE_UP:
                    begin
                        if (ent_rd.count != kst_pkg::COUNT_MAX)
                        begin
                            em_wdata.count = ent_rd.count + 16'd1;
                        end
                        em_we    = 1'b1;
                        res_next = '{status: kst_pkg::STATUS_OK, sid_out: 4'd0};
                    end
                    default:
                    begin
                        res_next = '{status: kst_pkg::STATUS_FAIL, sid_out: 4'd0};
                    end
                endcase
                if (em_we)
                begin
                    evld_next[sel_reg] = 1'b1;
                end
            end

            // hand result to the output register
            kst_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = kst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kst_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted transaction starts work
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg != kst_pkg::ST_IDLE)
        else $error("accepted transaction did not start work");

    // bound descriptor lies inside the process's table
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kst_pkg::ST_GWRITE |-> 32'(free_d_reg) < DESCRIPTORS)
        else $error("descriptor index out of range");

    // bound entry lies inside the table
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kst_pkg::ST_GWRITE |-> 32'(sel_reg) < TABLE_ENTRIES)
        else $error("entry index out of range");

    // no response while the descriptor memory is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kst_pkg::ST_CLEAR |-> !rsp_valid_reg)
        else $error("response during clearing pass");
`endif

endmodule
